// ----- rtl/qcsb_pkg.sv -----
// shared types, codes and the quadrature step table for the click speed binner
package qcsb_pkg;

    localparam int PIN_BITS      = 2;
    localparam int TIME_BITS     = 16;
    localparam int SUM_BITS      = 8;
    localparam int WEIGHT_BITS   = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 3;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 24;

    localparam logic [PIN_BITS-1:0] PINS_IDLE = 2'b11;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_DIR_NEGATE     = 3'd0,
        CFG_FAST_LIMIT     = 3'd1,
        CFG_VFAST_LIMIT    = 3'd2,
        CFG_WEIGHT_FAST    = 3'd3,
        CFG_WEIGHT_VFAST   = 3'd4
    } cfg_addr_t;

    typedef enum logic {
        ACT_PIN_EVENT = 1'b0,
        ACT_SNAPSHOT  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        SPEED_SLOW      = 2'd0,
        SPEED_FAST      = 2'd1,
        SPEED_VERY_FAST = 2'd2
    } speed_t;

    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_POS  = 2'sb01;
    localparam logic signed [1:0] DIR_NEG  = 2'sb11;

    typedef struct packed {
        logic   seen;
        logic   neg;
        speed_t speed;
    } click_t;

    // gray-code step for {previous pins, new pins}
    function automatic logic signed [1:0] quad_step(input logic [3:0] trans);
        logic signed [1:0] step;
        step = DIR_NONE;
        case (trans) inside
            4'd2, 4'd4, 4'd11, 4'd13: step = DIR_POS;
            4'd1, 4'd7, 4'd8, 4'd14:  step = DIR_NEG;
            default:                  step = DIR_NONE;
        endcase
        return step;
    endfunction

endpackage

// ----- rtl/quadrature_click_speed_binner.sv -----
// top level of the quadrature click speed binner
// Each request passes an input register and a result register, and the block takes one
// request every cycle while the output is not stalled; a request's result is registered
// in the result register after the input register, and while a result waits the input register
// takes one more request and then holds s_tready low until the result is taken.
// A pin event decodes the gray-code step and may complete a click that is binned by the
// time since the previous click; a snapshot request returns the plain and weighted sums
// of the live counters, wrapped to 8 bits, and clears them.
module quadrature_click_speed_binner import qcsb_pkg::*; #(
    parameter int COUNTER_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pin_data, pin_clock, now_ms[15:0], zero pad
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // action
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // click_seen, click_dir[1:0], speed_class[1:0], shift_sum[7:0], accel_shift[7:0], zero pad
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic                     dir_negate_reg;
    logic [TIME_BITS-1:0]     fast_limit_reg;
    logic [TIME_BITS-1:0]     vfast_limit_reg;
    logic [WEIGHT_BITS-1:0]   weight_fast_reg;
    logic [WEIGHT_BITS-1:0]   weight_vfast_reg;

    logic                     in_valid_reg;
    logic                     in_action_reg;
    logic [PIN_BITS-1:0]      in_pins_reg;
    logic [TIME_BITS-1:0]     in_now_reg;
    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg, out_data_next;

    logic                     out_free;
    logic                     fire;
    logic                     pin_en;
    logic                     snap_en;
    click_t                   click;
    logic [SUM_BITS-1:0]      shift_sum;
    logic [SUM_BITS-1:0]      accel_shift;
    logic signed [1:0]        click_dir;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign pin_en   = fire && (action_t'(in_action_reg) == ACT_PIN_EVENT);
    assign snap_en  = fire && (action_t'(in_action_reg) == ACT_SNAPSHOT);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_negate_reg   <= 1'b0;
            fast_limit_reg   <= 16'd200;
            vfast_limit_reg  <= 16'd50;
            weight_fast_reg  <= 8'd2;
            weight_vfast_reg <= 8'd4;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DIR_NEGATE:   dir_negate_reg   <= cfg_wdata[0];
                CFG_FAST_LIMIT:   fast_limit_reg   <= cfg_wdata;
                CFG_VFAST_LIMIT:  vfast_limit_reg  <= cfg_wdata;
                CFG_WEIGHT_FAST:  weight_fast_reg  <= cfg_wdata[WEIGHT_BITS-1:0];
                CFG_WEIGHT_VFAST: weight_vfast_reg <= cfg_wdata[WEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_pins_reg   <= s_tdata[1:0];
            in_now_reg    <= s_tdata[17:2];
        end
    end

    qcsb_decode u_decode (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .pin_en             (pin_en),
        .pins               (in_pins_reg),
        .now_ms             (in_now_reg),
        .direction_negate   (dir_negate_reg),
        .fast_limit_ms      (fast_limit_reg),
        .very_fast_limit_ms (vfast_limit_reg),
        .click              (click)
    );

    qcsb_counters #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_counters (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pin_en           (pin_en),
        .snap_en          (snap_en),
        .click            (click),
        .weight_fast      (weight_fast_reg),
        .weight_very_fast (weight_vfast_reg),
        .shift_sum        (shift_sum),
        .accel_shift      (accel_shift)
    );

    always_comb begin
        click_dir     = DIR_NONE;
        out_data_next = '0;
        if (action_t'(in_action_reg) == ACT_SNAPSHOT) begin
            out_data_next[12:5]  = shift_sum;
            out_data_next[20:13] = accel_shift;
        end else if (click.seen) begin
            click_dir           = click.neg ? DIR_NEG : DIR_POS;
            out_data_next[0]    = 1'b1;
            out_data_next[2:1]  = click_dir;
            out_data_next[4:3]  = click.speed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/qcsb_decode.sv -----
// quadrature step decode, detent click detection and speed classing
module qcsb_decode import qcsb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pin_en,
    input  logic [PIN_BITS-1:0]  pins,
    input  logic [TIME_BITS-1:0] now_ms,
    input  logic                 direction_negate,
    input  logic [TIME_BITS-1:0] fast_limit_ms,
    input  logic [TIME_BITS-1:0] very_fast_limit_ms,
    output click_t               click
);

    logic [PIN_BITS-1:0]  last_pins_reg,  last_pins_next;
    logic [7:0]           sub_pos_reg,    sub_pos_next;
    logic [TIME_BITS-1:0] last_time_reg,  last_time_next;
    logic signed [1:0]    step;
    logic signed [1:0]    step_signed;
    logic [7:0]           sub_sum;
    logic [TIME_BITS-1:0] gap;

    always_comb begin
        step        = quad_step({last_pins_reg, pins});
        step_signed = direction_negate ? -step : step;
        sub_sum     = sub_pos_reg + 8'(step_signed);
        gap         = now_ms - last_time_reg;

        click.seen  = (pins == PINS_IDLE) && (sub_sum != 8'd0);
        click.neg   = sub_sum[7];
        if (!click.seen) begin
            click.speed = SPEED_SLOW;
        end else if (gap < very_fast_limit_ms) begin
            click.speed = SPEED_VERY_FAST;
        end else if (gap < fast_limit_ms) begin
            click.speed = SPEED_FAST;
        end else begin
            click.speed = SPEED_SLOW;
        end

        last_pins_next = last_pins_reg;
        sub_pos_next   = sub_pos_reg;
        last_time_next = last_time_reg;
        if (pin_en) begin
            last_pins_next = pins;
            sub_pos_next   = click.seen ? 8'd0 : sub_sum;
            if (click.seen) begin
                last_time_next = now_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pins_reg <= PINS_IDLE;
            sub_pos_reg   <= '0;
            last_time_reg <= '0;
        end else begin
            last_pins_reg <= last_pins_next;
            sub_pos_reg   <= sub_pos_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

// ----- rtl/qcsb_counters.sv -----
// live click counters per speed class and snapshot sums
module qcsb_counters import qcsb_pkg::*; #(
    parameter int COUNTER_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pin_en,
    input  logic                   snap_en,
    input  click_t                 click,
    input  logic [WEIGHT_BITS-1:0] weight_fast,
    input  logic [WEIGHT_BITS-1:0] weight_very_fast,
    output logic [SUM_BITS-1:0]    shift_sum,
    output logic [SUM_BITS-1:0]    accel_shift
);

    localparam int NUM_CLASSES = 3;

    logic [COUNTER_BITS-1:0] live_reg  [NUM_CLASSES];
    logic [COUNTER_BITS-1:0] live_next [NUM_CLASSES];
    logic [SUM_BITS-1:0]     ext       [NUM_CLASSES];
    logic [COUNTER_BITS-1:0] delta;
    logic [2*SUM_BITS-1:0]   prod_fast;
    logic [2*SUM_BITS-1:0]   prod_vfast;

    always_comb begin
        delta = click.neg ? '1 : COUNTER_BITS'(1);
        for (int i = 0; i < NUM_CLASSES; i++) begin
            ext[i]       = SUM_BITS'($signed(live_reg[i]));
            live_next[i] = live_reg[i];
            if (snap_en) begin
                live_next[i] = '0;
            end else if (pin_en && click.seen && (click.speed == speed_t'(i))) begin
                live_next[i] = live_reg[i] + delta;
            end
        end
        prod_fast   = ext[1] * weight_fast;
        prod_vfast  = ext[2] * weight_very_fast;
        shift_sum   = ext[0] + ext[1] + ext[2];
        accel_shift = ext[0] + prod_fast[SUM_BITS-1:0] + prod_vfast[SUM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                live_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                live_reg[i] <= live_next[i];
            end
        end
    end

endmodule

// ----- rtl/qcsb_check.sv -----
// port-level checker for the click speed binner and its bind
module qcsb_check import qcsb_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_click_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
        else $error("direction or class without a click");

    a_click_no_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[20:5] == 16'd0)
        else $error("click result carries sums");

    a_click_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
            (m_tdata[2:1] == 2'b01 || m_tdata[2:1] == 2'b11) && m_tdata[4:3] != 2'b11)
        else $error("bad click direction or class");

endmodule

bind quadrature_click_speed_binner qcsb_check u_qcsb_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
